>>> hdl/rank_sort_all_pairs_assert.svh
// ----------------------------------------------------------------------------
// rank sort assertion macros
// property wrappers, empty when the design is synthesized
// ----------------------------------------------------------------------------
`ifndef RANK_SORT_ALL_PAIRS_ASSERT_SVH
`define RANK_SORT_ALL_PAIRS_ASSERT_SVH

`ifndef SYNTHESIS

`define RSAP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rank sort: forbidden condition seen");

`define RSAP_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rank sort: same-cycle implication failed");

`define RSAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rank sort: next-cycle implication failed");

`else

`define RSAP_ASSERT_NEVER(lbl, cond)
`define RSAP_ASSERT_IMPLIES(lbl, ante, cons)
`define RSAP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/rsap_pkg.sv
// ----------------------------------------------------------------------------
// rsap_pkg
// shared constants and types of the all-pairs rank sort
// ----------------------------------------------------------------------------
`default_nettype none

package rsap_pkg;

  localparam int MAX_ITEMS   = 16;
  localparam int IDX_W       = $clog2(MAX_ITEMS);
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W      = 32;
  localparam int SRC_W       = 4;
  localparam int OUT_RAW_W   = DATA_W + SRC_W;
  localparam int OUT_W       = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              final_item;
    logic [DATA_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             emitting;
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CMP,
    B_SCAT,
    B_RD,
    B_OUT
  } back_state_t;

endpackage

`default_nettype wire

>>> hdl/rsap_queue.sv
// ----------------------------------------------------------------------------
// rsap_queue
// input side: takes words from the stream and queues them for the ranker
// ----------------------------------------------------------------------------
`default_nettype none

module rsap_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [rsap_pkg::DATA_W-1:0] s_axis_tdata,  // sample
  input  wire logic                       s_axis_tlast,  // final_item
  output logic                            q_valid,
  input  wire logic                       q_ready,
  output rsap_pkg::item_t                 q_item
);

  rsap_pkg::item_t                  slots [rsap_pkg::QUEUE_DEPTH];
  logic [rsap_pkg::QPTR_W-1:0]      wr_ptr;
  logic [rsap_pkg::QPTR_W-1:0]      rd_ptr;
  logic [rsap_pkg::QCNT_W-1:0]      fill;
  logic                             push;
  logic                             pop;

  assign s_axis_tready = (fill != rsap_pkg::QCNT_W'(rsap_pkg::QUEUE_DEPTH));
  assign q_valid       = (fill != '0);
  assign q_item        = slots[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == rsap_pkg::QPTR_W'(rsap_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr + rsap_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == rsap_pkg::QPTR_W'(rsap_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr + rsap_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + rsap_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - rsap_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].sample     <= s_axis_tdata;
      slots[wr_ptr].final_item <= s_axis_tlast;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rsap_ranker.sv
// ----------------------------------------------------------------------------
// rsap_ranker
// ranks each value against the stored set with one comparator, then
// scatters ranks into an order table and streams the set out in order
// ----------------------------------------------------------------------------
`default_nettype none

module rsap_ranker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire rsap_pkg::item_t             q_item,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [rsap_pkg::OUT_W-1:0]       m_axis_tdata,  // sorted_value, source_index
  output logic                             m_axis_tlast,  // run_end
  output rsap_pkg::status_t                status
);

  localparam int IDX_W = rsap_pkg::IDX_W;
  localparam int CNT_W = rsap_pkg::CNT_W;

  rsap_pkg::back_state_t state, state_next;

  logic [rsap_pkg::DATA_W-1:0] mem [rsap_pkg::MAX_ITEMS];
  logic [rsap_pkg::DATA_W-1:0] rd_data;
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            rank  [rsap_pkg::MAX_ITEMS];
  logic [IDX_W-1:0]            order [rsap_pkg::MAX_ITEMS];

  logic [CNT_W-1:0]            n;
  logic [CNT_W-1:0]            j;
  logic [IDX_W-1:0]            r;
  logic [IDX_W-1:0]            emit_idx;
  logic [IDX_W-1:0]            new_rank;
  logic [IDX_W-1:0]            st_idx;
  logic                        st_valid;
  logic [rsap_pkg::DATA_W-1:0] cur_sample;
  logic                        cur_final;

  logic                        full;
  logic                        cmp_done;
  logic                        scan_last;
  logic                        emit_last;
  logic                        beats;
  logic [rsap_pkg::SRC_W-1:0]  src_index;

  assign full      = (n == CNT_W'(rsap_pkg::MAX_ITEMS));
  assign cmp_done  = (j == n) && !st_valid;
  assign scan_last = ((j + CNT_W'(1)) == n);
  assign emit_last = ((CNT_W'(r) + CNT_W'(1)) == n);
  // stored value beats the new one (ranks above it); on a tie the later arrival ranks higher
  assign beats     = $signed(rd_data) > $signed(cur_sample);
  assign src_index = rsap_pkg::SRC_W'(emit_idx);

  assign m_axis_tdata = rsap_pkg::OUT_W'({src_index, rd_data});
  assign m_axis_tlast = emit_last;

  assign status.count    = n;
  assign status.emitting = (state == rsap_pkg::B_SCAT) || (state == rsap_pkg::B_RD) ||
                           (state == rsap_pkg::B_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsap_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    q_ready       = 1'b0;
    m_axis_tvalid = 1'b0;
    rd_addr       = j[IDX_W-1:0];
    unique case (state)
      rsap_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          priority if (!full) begin
            state_next = rsap_pkg::B_CMP;
          end else if (q_item.final_item) begin
            state_next = rsap_pkg::B_SCAT;
          end else begin
            state_next = rsap_pkg::B_IDLE;
          end
        end
      end
      rsap_pkg::B_CMP: begin
        if (cmp_done) begin
          state_next = cur_final ? rsap_pkg::B_SCAT : rsap_pkg::B_IDLE;
        end
      end
      rsap_pkg::B_SCAT: begin
        if (scan_last) begin
          state_next = rsap_pkg::B_RD;
        end
      end
      rsap_pkg::B_RD: begin
        rd_addr    = order[r];
        state_next = rsap_pkg::B_OUT;
      end
      rsap_pkg::B_OUT: begin
        rd_addr       = order[r];
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_next = emit_last ? rsap_pkg::B_IDLE : rsap_pkg::B_RD;
        end
      end
      default: begin
        state_next = rsap_pkg::B_IDLE;
      end
    endcase
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      n        <= '0;
      j        <= '0;
      r        <= '0;
      st_valid <= 1'b0;
    end else begin
      unique case (state)
        rsap_pkg::B_IDLE: begin
          if (q_valid) begin
            j        <= '0;
            st_valid <= 1'b0;
          end
        end
        rsap_pkg::B_CMP: begin
          st_valid <= (j != n);
          if (j != n) begin
            j <= j + CNT_W'(1);
          end
          if (cmp_done) begin
            n <= n + CNT_W'(1);
            j <= '0;
          end
        end
        rsap_pkg::B_SCAT: begin
          j <= j + CNT_W'(1);
          r <= '0;
        end
        rsap_pkg::B_RD: begin
          r <= r;
        end
        rsap_pkg::B_OUT: begin
          if (m_axis_tready) begin
            if (emit_last) begin
              n <= '0;
            end else begin
              r <= r + IDX_W'(1);
            end
          end
        end
        default: begin
          st_valid <= 1'b0;
        end
      endcase
    end
  end

  // value store, ranks and order table
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (state == rsap_pkg::B_IDLE && q_valid) begin
      cur_sample <= q_item.sample;
      cur_final  <= q_item.final_item;
      new_rank   <= '0;
    end
    if (state == rsap_pkg::B_CMP) begin
      st_idx <= j[IDX_W-1:0];
      if (st_valid) begin
        if (beats) begin
          rank[st_idx] <= rank[st_idx] + IDX_W'(1);
        end else begin
          new_rank <= new_rank + IDX_W'(1);
        end
      end
      if (cmp_done) begin
        mem[n[IDX_W-1:0]]  <= cur_sample;
        rank[n[IDX_W-1:0]] <= new_rank;
      end
    end
    if (state == rsap_pkg::B_SCAT) begin
      order[rank[j[IDX_W-1:0]]] <= j[IDX_W-1:0];
    end
    if (state == rsap_pkg::B_RD) begin
      emit_idx <= order[r];
    end
  end

endmodule

`default_nettype wire

>>> hdl/rank_sort_all_pairs.sv
// the ranker takes a new input word only after its one comparator has walked the
//   whole store for the previous value, so words wait in the queue meanwhile
// after the final value is ranked, the order table is built, then each result is read
//   (B_RD) and offered (B_OUT), held in B_OUT while m_axis_tready is low
// input words queue in a two-entry buffer; the source stalls once both entries wait
// reset: synchronous, clears the queue, the loaded count and the sequencer state
// ----------------------------------------------------------------------------
// rank_sort_all_pairs
// enumeration sort of up to MAX_ITEMS signed Q16.16 values, emitted in ascending order
// ----------------------------------------------------------------------------
`default_nettype none

module rank_sort_all_pairs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [rsap_pkg::DATA_W-1:0]  s_axis_tdata,  // sample
  input  wire logic                         s_axis_tlast,  // final_item
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [rsap_pkg::OUT_W-1:0]        m_axis_tdata,  // sorted_value, source_index, pad
  output logic                              m_axis_tlast   // run_end
);

  `include "rank_sort_all_pairs_assert.svh"

  logic              q_valid;
  logic              q_ready;
  rsap_pkg::item_t   q_item;
  rsap_pkg::status_t status;
  logic              run_done;

  assign run_done = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  rsap_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  rsap_ranker u_ranker (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .status        (status)
  );

  `RSAP_ASSERT_NEVER(a_count_bound, status.count > rsap_pkg::CNT_W'(rsap_pkg::MAX_ITEMS))
  `RSAP_ASSERT_IMPLIES(a_no_pop_while_emit, status.emitting, !q_ready)
  `RSAP_ASSERT_NEXT(a_empty_after_run, run_done, status.count == '0)
  `RSAP_ASSERT_IMPLIES(a_full_queue_holds, !s_axis_tready, q_valid)

endmodule

`default_nettype wire
